// ===== sv/assert_macros.svh =====
// Assertion macros shared by the transmit buffer pool manager RTL.
// Each macro expects signals clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tbpm_pkg.sv =====
// Package for the transmit buffer pool manager: sizes, codes and the
// command and status structs between controller and datapath. No dependencies.
package tbpm_pkg;

  localparam int BUF_COUNT = 8;
  localparam int IDX_W     = (BUF_COUNT > 1) ? $clog2(BUF_COUNT) : 1;
  localparam int IN_IDX_W  = 3;
  localparam int TIME_W    = 32;

  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_QUEUE = 2'd1;
  localparam logic [1:0] ACT_FREE  = 2'd2;
  localparam logic [1:0] ACT_PICK  = 2'd3;

  localparam logic [1:0] ST_FREE     = 2'd0;
  localparam logic [1:0] ST_BUSY     = 2'd1;
  localparam logic [1:0] ST_WAIT     = 2'd2;
  localparam logic [1:0] ST_WAIT_ACK = 2'd3;

  typedef struct packed {
    logic load;        // latch the accepted request and clear the result
    logic try_np;      // take the round-robin buffer if it is free
    logic scan_alloc;  // test one buffer of the lowest-free scan
    logic update;      // apply a queue or free request
    logic scan_pick;   // test one buffer of the oldest-waiting scan
    logic emit;        // move the finished result into the output register
  } tbpm_cmd_t;

  typedef struct packed {
    logic [1:0] act;       // latched action
    logic       rd_free;   // buffer at the current read address is free
    logic       scan_last; // scan index sits on the last buffer
    logic       out_room;  // output register can take a result this cycle
  } tbpm_stat_t;

endpackage

// ===== sv/tbpm_ctrl.sv =====
// Controller state machine of the transmit buffer pool manager.
// Depends on tbpm_pkg for the command and status structs.
module tbpm_ctrl
  import tbpm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  tbpm_stat_t st,
  output tbpm_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_DECODE     = 3'd1;
  localparam logic [2:0] S_ALLOC_TRY  = 3'd2;
  localparam logic [2:0] S_ALLOC_SCAN = 3'd3;
  localparam logic [2:0] S_UPDATE     = 3'd4;
  localparam logic [2:0] S_PICK       = 3'd5;
  localparam logic [2:0] S_FIN        = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // The input side stays closed while reset is held.
  assign in_stall = !rst_n || (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (st.act)
          ACT_ALLOC: state_nxt = S_ALLOC_TRY;
          ACT_PICK:  state_nxt = S_PICK;
          default:   state_nxt = S_UPDATE;
        endcase
      end
      S_ALLOC_TRY: begin
        cmd.try_np = 1'b1;
        state_nxt  = st.rd_free ? S_FIN : S_ALLOC_SCAN;
      end
      S_ALLOC_SCAN: begin
        cmd.scan_alloc = 1'b1;
        if (st.rd_free || st.scan_last) begin
          state_nxt = S_FIN;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = S_FIN;
      end
      S_PICK: begin
        cmd.scan_pick = 1'b1;
        if (st.scan_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (st.out_room) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/tbpm_dp.sv =====
// Datapath of the transmit buffer pool manager: buffer status and stamps,
// round-robin pointer, scan index, result and output register. Uses tbpm_pkg.
module tbpm_dp
  import tbpm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  tbpm_cmd_t           cmd,
  output tbpm_stat_t          st,
  input  logic [1:0]          in_action,
  input  logic [IN_IDX_W-1:0] in_buf_index,
  input  logic                in_ack_required,
  input  logic [TIME_W-1:0]   in_now,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_ok,
  output logic [2:0]          out_result_index
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUF_COUNT - 1);

  logic [1:0]          status_r [BUF_COUNT];
  logic [TIME_W-1:0]   stamp_r  [BUF_COUNT];
  logic [IDX_W-1:0]    np_r;
  logic [IDX_W-1:0]    scan_r;

  logic [1:0]          act_r;
  logic [IN_IDX_W-1:0] idx_r;
  logic                ack_r;
  logic [TIME_W-1:0]   now_r;

  logic                res_ok_r;
  logic [IDX_W-1:0]    res_idx_r;
  logic [TIME_W-1:0]   best_r;

  logic                out_valid_r;
  logic                out_ok_r;
  logic [2:0]          out_idx_r;

  logic [IDX_W-1:0]    rd_addr;
  logic [1:0]          rd_status;
  logic                rd_wait;
  logic [TIME_W-1:0]   age;
  logic                pick_better;
  logic [IDX_W+IN_IDX_W-1:0] idx_wide;
  logic [IDX_W-1:0]    upd_addr;
  logic                upd_in_range;
  logic [IDX_W+2:0]    res_wide;
  logic                take_np;
  logic                take_scan;

  // One status read per cycle: the round-robin pointer during the first
  // allocation try, the scan index otherwise.
  assign rd_addr   = cmd.try_np ? np_r : scan_r;
  assign rd_status = status_r[rd_addr];
  assign rd_wait   = rd_status inside {ST_WAIT, ST_WAIT_ACK};

  assign age         = now_r - stamp_r[scan_r];
  assign pick_better = rd_wait && (!res_ok_r || (age > best_r));

  assign idx_wide     = {{IDX_W{1'b0}}, idx_r};
  assign upd_addr     = idx_wide[IDX_W-1:0];
  assign upd_in_range = idx_wide < (IDX_W + IN_IDX_W)'(BUF_COUNT);

  assign take_np   = cmd.try_np && (rd_status == ST_FREE);
  assign take_scan = cmd.scan_alloc && (rd_status == ST_FREE);

  assign st.act       = act_r;
  assign st.rd_free   = (rd_status == ST_FREE);
  assign st.scan_last = (scan_r == LAST_IDX);
  assign st.out_room  = !out_valid_r || !out_stall;

  // Request latch.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action;
      idx_r <= in_buf_index;
      ack_r <= in_ack_required;
      now_r <= in_now;
    end
  end

  // Scan index and running result.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_r    <= '0;
      res_ok_r  <= 1'b0;
      res_idx_r <= '0;
      best_r    <= '0;
    end else begin
      if (cmd.scan_alloc || cmd.scan_pick) begin
        scan_r <= scan_r + IDX_W'(1);
      end
      if (take_np) begin
        res_ok_r  <= 1'b1;
        res_idx_r <= np_r;
      end
      if (take_scan) begin
        res_ok_r  <= 1'b1;
        res_idx_r <= scan_r;
      end
      if (cmd.update) begin
        res_ok_r <= upd_in_range;
      end
      if (cmd.scan_pick && pick_better) begin
        res_ok_r  <= 1'b1;
        res_idx_r <= scan_r;
        best_r    <= age;
      end
    end
  end

  // Buffer status, stamps and the round-robin pointer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BUF_COUNT; i++) begin
        status_r[i] <= ST_FREE;
        stamp_r[i]  <= '0;
      end
      np_r <= '0;
    end else begin
      if (take_np) begin
        status_r[np_r] <= ST_BUSY;
        stamp_r[np_r]  <= now_r;
        np_r           <= (np_r == LAST_IDX) ? '0 : np_r + IDX_W'(1);
      end else if (take_scan) begin
        status_r[scan_r] <= ST_BUSY;
        stamp_r[scan_r]  <= now_r;
      end else if (cmd.update && upd_in_range) begin
        if (act_r == ACT_QUEUE) begin
          status_r[upd_addr] <= ack_r ? ST_WAIT_ACK : ST_WAIT;
        end else begin
          status_r[upd_addr] <= ST_FREE;
        end
      end
    end
  end

  // Output register.
  assign res_wide = {3'b000, res_idx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_ok_r  <= res_ok_r;
      out_idx_r <= res_ok_r ? res_wide[2:0] : 3'b000;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_ok           = out_ok_r;
  assign out_result_index = out_idx_r;

endmodule

// ===== sv/tx_buffer_pool_manager_unit.sv =====
// Top level of the transmit buffer pool manager.
// Instantiates tbpm_ctrl and tbpm_dp; uses tbpm_pkg and assert_macros.svh.
//
// This block keeps a pool of BUF_COUNT transmit buffers, each with a status
// (free, busy, waiting to send, waiting to send with acknowledge) and a 32-bit
// time stamp, and handles one request per input transaction, giving exactly
// one result transaction for each. Allocate takes the round-robin buffer if
// it is free, otherwise the lowest-numbered free buffer; the taken buffer is
// marked busy and stamped with now. Queue and free rewrite a buffer's status.
// Pick oldest reports the waiting buffer whose wrapped age (now minus stamp)
// is greatest, the lower index winning a tie, and changes no state. Requests
// are handled one at a time. Queue, free and an allocation that finds the
// round-robin buffer free need no scan; an allocation that falls back to the
// lowest-free scan visits buffers in index order until it finds a free one,
// at most BUF_COUNT of them; pick oldest always visits all BUF_COUNT buffers.
// The scans dominate, since the datapath reads one buffer's status and stamp
// per cycle and does one 32-bit age subtract and compare per cycle. The
// output register lets a new request be accepted while the previous result
// still waits to be taken. After reset every buffer is free and every stamp
// is zero, with no clearing pass.
`include "assert_macros.svh"

module tx_buffer_pool_manager_unit
  import tbpm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_action,
  input  logic [IN_IDX_W-1:0] in_buf_index,
  input  logic                in_ack_required,
  input  logic [TIME_W-1:0]   in_now,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_ok,
  output logic [2:0]          out_result_index
);

  tbpm_cmd_t  cmd;
  tbpm_stat_t st;

  // The controller sequences each request; the datapath holds the buffer and request state.
  tbpm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  tbpm_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .in_action        (in_action),
    .in_buf_index     (in_buf_index),
    .in_ack_required  (in_ack_required),
    .in_now           (in_now),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ok           (out_ok),
    .out_result_index (out_result_index)
  );

  // A newly accepted request keeps the input side closed while it is worked on.
  `ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accept while busy")

  // A result is only moved into the output register when it has room.
  `ASSERT_SAME(a_emit_has_room, cmd.emit, st.out_room, "result would overwrite output")

  // While the input side is open, no request is in progress.
  `ASSERT_SAME(a_idle_no_work, !in_stall,
    !(cmd.try_np || cmd.scan_alloc || cmd.update || cmd.scan_pick || cmd.emit),
    "work command while idle")

  // Emitting a result always makes the output valid in the next cycle.
  `ASSERT_NEXT(a_emit_gives_valid, cmd.emit, out_valid, "emitted result not shown")

endmodule
